// ===== hw/rtl/ccrp_pkg.sv =====
// shared types and codes for the character class run pattern checker
package ccrp_pkg;

    typedef logic [2:0] t_cls;

    localparam t_cls CLS_UPPER  = 3'd0;
    localparam t_cls CLS_LOWER  = 3'd1;
    localparam t_cls CLS_SYMBOL = 3'd2;
    localparam t_cls CLS_DIGIT  = 3'd3;
    localparam t_cls CLS_NONE   = 3'd4;

    typedef logic [1:0] t_reason;

    localparam t_reason REASON_OK       = 2'd0;
    localparam t_reason REASON_INVALID  = 2'd1;
    localparam t_reason REASON_COUNT    = 2'd2;
    localparam t_reason REASON_MISMATCH = 2'd3;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_EXPECTED_RUNS = 2'd0;
    localparam t_cfg_idx CFG_RUN_CLASSES   = 2'd1;
    localparam t_cfg_idx CFG_RUN_LENGTHS   = 2'd2;

    localparam int CFG_DATA_W = 32;

    localparam logic [2:0]  EXPECTED_RUNS_RST = 3'd4;
    localparam logic [7:0]  RUN_CLASSES_RST   = 8'd177;
    localparam logic [31:0] RUN_LENGTHS_RST   = 32'h0303_0303;

    typedef struct packed {
        t_cls cls;
        logic last;
    } t_item;

    typedef struct packed {
        logic [2:0]  expected_runs;
        logic [7:0]  run_classes;
        logic [31:0] run_lengths;
    } t_cfg;

endpackage

// ===== hw/rtl/ccrp_front.sv =====
// front end: classifies each byte and holds it in one register stage
module ccrp_front
    import ccrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_char_byte,
    input  logic       i_last_byte,
    output logic       o_ready,
    output logic       o_valid,
    output t_item      o_item,
    input  logic       i_q_full
);

    logic  r_valid;
    t_item r_item;
    logic  n_valid;
    logic  take;
    logic  drain;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        if (b >= 8'h41 && b <= 8'h5A) begin
            c = CLS_UPPER;
        end else if (b >= 8'h61 && b <= 8'h7A) begin
            c = CLS_LOWER;
        end else if (b >= 8'h30 && b <= 8'h39) begin
            c = CLS_DIGIT;
        end else if (b >= 8'd33 && b <= 8'd126) begin
            c = CLS_SYMBOL;
        end else begin
            c = CLS_NONE;
        end
        return c;
    endfunction

    assign drain   = r_valid && !i_q_full;
    assign o_ready = !r_valid || !i_q_full;
    assign take    = i_push && o_ready;
    assign o_valid = drain;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (drain) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.cls  <= classify(i_char_byte);
            r_item.last <= i_last_byte;
        end
    end

endmodule

// ===== hw/rtl/ccrp_queue.sv =====
// small first-in first-out queue between the front end and the run tracker
module ccrp_queue
    import ccrp_pkg::*;
#(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count, n_count;
    logic             do_wr, do_rd;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("queue count above depth");

endmodule

// ===== hw/rtl/ccrp_back.sv =====
// back end: tracks class runs, checks them against the pattern, holds the result
module ccrp_back
    import ccrp_pkg::*;
#(
    parameter int PATTERN_MAX = 4,
    parameter int LENGTH_BITS = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_empty,
    input  t_item   i_item,
    output logic    o_q_rd,
    input  logic    i_pop,
    output logic    o_empty,
    output logic    o_accepted,
    output t_reason o_fail_reason
);

    localparam int CNW       = $clog2(PATTERN_MAX + 2);
    localparam int IW        = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int IDX_N     = 2 ** IW;
    localparam int CLS_PAD_W = (2 * IDX_N > 8) ? 2 * IDX_N : 8;
    localparam int LEN_PAD_W = (LENGTH_BITS * IDX_N > 32) ? LENGTH_BITS * IDX_N : 32;
    localparam int CMPW      = (CNW > 3) ? CNW : 3;
    localparam int LW        = LENGTH_BITS + 1;

    t_cls             r_cur, n_cur;
    logic [LW-1:0]    r_len, n_len;
    logic [CNW-1:0]   r_runs, n_runs;
    logic             r_inv, n_inv;
    logic             r_mis, n_mis;
    logic             r_out_valid, n_out_valid;
    logic             r_out_accepted;
    t_reason          r_out_reason;

    logic [CLS_PAD_W-1:0]   cls_pad;
    logic [LEN_PAD_W-1:0]   len_pad;
    logic [1:0]             want_cls [IDX_N];
    logic [LENGTH_BITS-1:0] want_len [IDX_N];

    logic           out_free, take;
    logic           inv1, close_a, close_b, mis_a, mis_b, count_ok;
    t_cls           cur1;
    logic [LW-1:0]  len1;
    logic [CNW-1:0] runs1, runs2;
    t_reason        reason;

    localparam logic [CNW-1:0] RUNS_SAT = CNW'(PATTERN_MAX + 1);

    assign cls_pad = CLS_PAD_W'(i_cfg.run_classes);
    assign len_pad = LEN_PAD_W'(i_cfg.run_lengths);

    always_comb begin
        for (int k = 0; k < IDX_N; k++) begin
            want_cls[k] = cls_pad[2*k +: 2];
            want_len[k] = len_pad[LENGTH_BITS*k +: LENGTH_BITS];
        end
    end

    // a result needs the output slot; other beats never wait
    assign out_free = !r_out_valid || i_pop;
    assign take     = !i_q_empty && (!i_item.last || out_free);
    assign o_q_rd   = take;

    always_comb begin
        inv1    = r_inv;
        cur1    = r_cur;
        len1    = r_len;
        close_a = 1'b0;
        if (!r_inv) begin
            if (i_item.cls == CLS_NONE) begin
                inv1 = 1'b1;
            end else if (i_item.cls == r_cur) begin
                if (!r_len[LENGTH_BITS]) begin
                    len1 = r_len + 1'b1;
                end
            end else begin
                close_a = (r_cur != CLS_NONE);
                cur1    = i_item.cls;
                len1    = LW'(1);
            end
        end

        mis_a = close_a && (r_runs < CNW'(PATTERN_MAX))
             && ((t_cls'(want_cls[r_runs[IW-1:0]]) != r_cur)
                 || (LW'(want_len[r_runs[IW-1:0]]) != r_len));
        runs1 = (close_a && r_runs != RUNS_SAT) ? r_runs + 1'b1 : r_runs;

        // the last beat closes whatever run is still open, unless an invalid byte was seen
        close_b = i_item.last && !inv1 && (cur1 != CLS_NONE);
        mis_b   = close_b && (runs1 < CNW'(PATTERN_MAX))
               && ((t_cls'(want_cls[runs1[IW-1:0]]) != cur1)
                   || (LW'(want_len[runs1[IW-1:0]]) != len1));
        runs2   = (close_b && runs1 != RUNS_SAT) ? runs1 + 1'b1 : runs1;

        count_ok = (i_cfg.expected_runs != 3'd0)
                && (CMPW'(i_cfg.expected_runs) <= CMPW'(PATTERN_MAX))
                && (CMPW'(runs2) == CMPW'(i_cfg.expected_runs));

        if (inv1) begin
            reason = REASON_INVALID;
        end else if (!count_ok) begin
            reason = REASON_COUNT;
        end else if (r_mis || mis_a || mis_b) begin
            reason = REASON_MISMATCH;
        end else begin
            reason = REASON_OK;
        end
    end

    always_comb begin
        n_cur       = r_cur;
        n_len       = r_len;
        n_runs      = r_runs;
        n_inv       = r_inv;
        n_mis       = r_mis;
        n_out_valid = r_out_valid && !i_pop;
        if (take) begin
            if (i_item.last) begin
                n_cur       = CLS_NONE;
                n_len       = '0;
                n_runs      = '0;
                n_inv       = 1'b0;
                n_mis       = 1'b0;
                n_out_valid = 1'b1;
            end else begin
                n_cur  = cur1;
                n_len  = len1;
                n_runs = runs1;
                n_inv  = inv1;
                n_mis  = r_mis || mis_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= CLS_NONE;
            r_len       <= '0;
            r_runs      <= '0;
            r_inv       <= 1'b0;
            r_mis       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cur       <= n_cur;
            r_len       <= n_len;
            r_runs      <= n_runs;
            r_inv       <= n_inv;
            r_mis       <= n_mis;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_item.last) begin
            r_out_accepted <= (reason == REASON_OK);
            r_out_reason   <= reason;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_accepted    = r_out_accepted;
    assign o_fail_reason = r_out_reason;

    a_pass_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_accepted == (r_out_reason == REASON_OK)))
        else $error("pass flag disagrees with reason");

    a_runs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_runs <= RUNS_SAT)
        else $error("run count above saturation");

    a_open_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur == CLS_NONE) == (r_len == '0))
        else $error("run length disagrees with open run");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_item.last) |=> (r_runs == '0 && r_cur == CLS_NONE && !r_inv && !r_mis))
        else $error("state not cleared after last beat");

endmodule

// ===== hw/rtl/char_class_run_pattern_check.sv =====
// top level of the character class run pattern checker
//
// Password bytes enter one beat per clock while full is low and results leave one beat
// per clock when pop keeps up: the front end classifies a byte into a register stage, a
// four-entry queue carries it to the run tracker, and the tracker handles one byte per
// cycle unless a last byte waits for the output slot, and writes a result into its output
// register on the last byte. Each side can stall on its own; full rises only when the
// queue and the front register are both occupied. Configuration writes take effect at
// once and are meant for an idle block.
module char_class_run_pattern_check
    import ccrp_pkg::*;
#(
    parameter int PATTERN_MAX = 4,
    parameter int LENGTH_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_char_byte,
    input  logic                  i_last_byte,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_accepted,
    output logic [1:0]            o_fail_reason,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int QUEUE_DEPTH = 4;

    logic [2:0]  r_expected_runs;
    logic [7:0]  r_run_classes;
    logic [31:0] r_run_lengths;
    t_cfg        cfg;

    logic  front_ready, front_valid;
    t_item front_item;
    logic  q_full, q_empty, q_rd;
    t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_runs <= EXPECTED_RUNS_RST;
            r_run_classes   <= RUN_CLASSES_RST;
            r_run_lengths   <= RUN_LENGTHS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXPECTED_RUNS: r_expected_runs <= i_cfg_data[2:0];
                CFG_RUN_CLASSES:   r_run_classes   <= i_cfg_data[7:0];
                CFG_RUN_LENGTHS:   r_run_lengths   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign cfg.expected_runs = r_expected_runs;
    assign cfg.run_classes   = r_run_classes;
    assign cfg.run_lengths   = r_run_lengths;

    assign full = !front_ready;

    ccrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_char_byte (i_char_byte),
        .i_last_byte (i_last_byte),
        .o_ready     (front_ready),
        .o_valid     (front_valid),
        .o_item      (front_item),
        .i_q_full    (q_full)
    );

    ccrp_queue #(
        .WIDTH ($bits(t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_wdata (front_item),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_item),
        .o_empty (q_empty)
    );

    ccrp_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_empty     (q_empty),
        .i_item        (q_item),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_accepted    (o_accepted),
        .o_fail_reason (o_fail_reason)
    );

endmodule
